FILE: hdl/ptap_pkg.sv
// Shared types and constants for the pixel to ARGB converter with opacity probe.
`timescale 1ns / 1ps

package ptap_pkg;

    localparam int DIM_W   = 13;
    localparam int PIXEL_W = 32;

    typedef enum logic [1:0] {
        FMT_RGBA8888 = 2'd0,
        FMT_RGBX8888 = 2'd1,
        FMT_RGB565   = 2'd2,
        FMT_PASS     = 2'd3
    } t_pixel_format;

    typedef enum logic [1:0] {
        CFG_PIXEL_FORMAT = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2,
        CFG_AUTO_OPACITY = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic sampled;
        logic last;
    } t_item_ctl;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

endpackage

FILE: hdl/ptap_grid.sv
// Position counter and incremental sample grid tracker for one axis of the frame.
`timescale 1ns / 1ps

module ptap_grid
    import ptap_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096,
    parameter int GRID_POINTS   = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_restart,
    input  logic                             i_adv,
    input  logic [$clog2(MAX_DIMENSION)-1:0] i_span,
    output logic                             o_sampled,
    output logic                             o_at_end
);

    localparam int CW   = $clog2(MAX_DIMENSION);
    localparam int GW   = $clog2(GRID_POINTS * MAX_DIMENSION);
    localparam int STEP = GRID_POINTS - 1;

    // r_acc holds g * span for the next grid point g, and r_lim holds (pos + 1) * STEP.
    // The point lies on the current position when r_acc is below r_lim.
    logic [CW-1:0] r_pos, n_pos;
    logic [GW-1:0] r_acc, n_acc;
    logic [GW-1:0] r_lim, n_lim;
    logic          small_span;
    logic          on_point;

    assign small_span = (32'(i_span) < 32'(STEP));
    assign on_point   = (r_acc < r_lim);
    assign o_sampled  = small_span || on_point;
    assign o_at_end   = (r_pos == i_span);

    always_comb begin
        n_pos = r_pos;
        n_acc = r_acc;
        n_lim = r_lim;
        if (i_restart || (i_adv && o_at_end)) begin
            n_pos = '0;
            n_acc = '0;
            n_lim = GW'(STEP);
        end else if (i_adv) begin
            n_pos = r_pos + CW'(1);
            n_lim = r_lim + GW'(STEP);
            if (!small_span && on_point) begin
                n_acc = r_acc + GW'(i_span);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_acc <= '0;
            r_lim <= GW'(STEP);
        end else begin
            r_pos <= n_pos;
            r_acc <= n_acc;
            r_lim <= n_lim;
        end
    end

endmodule

FILE: hdl/ptap_out.sv
// Result stage: pixel conversion, frame opacity flag and the output register.
`timescale 1ns / 1ps

module ptap_out
    import ptap_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_restart,
    input  logic               i_move,
    input  logic [PIXEL_W-1:0] i_word,
    input  t_item_ctl          i_ctl,
    input  t_pixel_format      i_format,
    input  logic               i_auto,
    input  logic               i_argb_ready,
    output logic               o_free,
    output logic               o_argb_valid,
    output logic [PIXEL_W-1:0] o_argb_word,
    output logic               o_frame_last,
    output logic               o_verdict_valid,
    output logic               o_want_xrgb
);

    logic               r_valid;
    logic [PIXEL_W-1:0] r_word;
    logic               r_last;
    logic               r_verdict;
    logic               r_xrgb;
    logic               r_all_opaque, n_all_opaque;
    logic [PIXEL_W-1:0] conv_word;
    logic               opaque_now;
    logic               verdict;
    logic [4:0]         red5;
    logic [5:0]         green6;
    logic [4:0]         blue5;

    assign red5   = i_word[15:11];
    assign green6 = i_word[10:5];
    assign blue5  = i_word[4:0];

    always_comb begin
        case (i_format)
            FMT_RGB565: begin
                conv_word = {ALPHA_OPAQUE, red5, red5[4:2], green6, green6[5:4],
                             blue5, blue5[4:2]};
            end
            FMT_RGBA8888, FMT_RGBX8888: begin
                conv_word = {i_word[31:24], i_word[7:0], i_word[15:8], i_word[23:16]};
            end
            default: begin
                conv_word = i_word;
            end
        endcase
    end

    assign opaque_now = r_all_opaque &&
                        !(i_ctl.sampled && (i_format == FMT_RGBA8888) &&
                          (conv_word[31:24] != ALPHA_OPAQUE));
    assign verdict    = i_ctl.last && i_auto;

    always_comb begin
        n_all_opaque = r_all_opaque;
        if (i_restart) begin
            n_all_opaque = 1'b1;
        end else if (i_move) begin
            n_all_opaque = i_ctl.last ? 1'b1 : opaque_now;
        end
    end

    assign o_free = !r_valid || i_argb_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_all_opaque <= 1'b1;
        end else begin
            r_all_opaque <= n_all_opaque;
            if (i_move) begin
                r_valid <= 1'b1;
            end else if (i_argb_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_move) begin
            r_word    <= conv_word;
            r_last    <= i_ctl.last;
            r_verdict <= verdict;
            r_xrgb    <= verdict && opaque_now;
        end
    end

    assign o_argb_valid    = r_valid;
    assign o_argb_word     = r_word;
    assign o_frame_last    = r_last;
    assign o_verdict_valid = r_verdict;
    assign o_want_xrgb     = r_xrgb;

endmodule

FILE: hdl/pixel_to_argb_with_opacity_probe_unit.sv
// Top level of the pixel to ARGB8888 converter with frame opacity probe.
`timescale 1ns / 1ps

// Takes one source pixel word per clock in raster order and returns one ARGB8888 word per
// clock, as long as the output side keeps taking words; each word passes through the input
// register and then the result register, which set the rate and each hold one word.
// RGB565 is widened by bit replication with opaque alpha, RGBA and RGBX have red and blue
// swapped, and any other format passes through. With auto opacity on, the last word of each
// frame carries the verdict on whether every alpha on the sample grid was opaque. The grid
// positions are followed with running sums, so no division takes place. Any configuration
// write restarts the frame, and the configuration channel is always ready.

module pixel_to_argb_with_opacity_probe_unit
    import ptap_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096,
    parameter int GRID_POINTS   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [DIM_W-1:0]   i_cfg_data,
    input  logic               i_pixel_valid,
    output logic               o_pixel_ready,
    input  logic [PIXEL_W-1:0] i_pixel_word,
    output logic               o_argb_valid,
    input  logic               i_argb_ready,
    output logic [PIXEL_W-1:0] o_argb_word,
    output logic               o_frame_last,
    output logic               o_verdict_valid,
    output logic               o_want_xrgb
);

    localparam int CW = $clog2(MAX_DIMENSION);

    t_pixel_format      r_format;
    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;
    logic               r_auto;
    logic               r_s1_valid;
    logic [PIXEL_W-1:0] r_s1_word;
    t_item_ctl          r_s1_ctl;
    logic               cfg_write;
    logic               pixel_take;
    logic               out_free;
    logic               s1_move;
    logic [CW-1:0]      col_span;
    logic [CW-1:0]      row_span;
    logic               col_sampled;
    logic               col_end;
    logic               row_sampled;
    logic               row_end;

    function automatic logic [CW-1:0] dim_span(input logic [DIM_W-1:0] v);
        logic [CW-1:0] s;
        if (v == '0) begin
            s = '0;
        end else if (32'(v) > 32'(MAX_DIMENSION)) begin
            s = CW'(MAX_DIMENSION - 1);
        end else begin
            s = CW'(v - DIM_W'(1));
        end
        return s;
    endfunction

    assign col_span = dim_span(r_width);
    assign row_span = dim_span(r_height);

    assign o_cfg_ready   = 1'b1;
    assign cfg_write     = i_cfg_valid;
    assign s1_move       = r_s1_valid && out_free;
    assign o_pixel_ready = !r_s1_valid || out_free;
    assign pixel_take    = i_pixel_valid && o_pixel_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_RGBA8888;
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
            r_auto   <= 1'b0;
        end else if (cfg_write) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_PIXEL_FORMAT: r_format <= t_pixel_format'(i_cfg_data[1:0]);
                CFG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_height <= i_cfg_data;
                CFG_AUTO_OPACITY: r_auto   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (pixel_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pixel_take) begin
            r_s1_word        <= i_pixel_word;
            r_s1_ctl.sampled <= col_sampled && row_sampled;
            r_s1_ctl.last    <= col_end && row_end;
        end
    end

    ptap_grid #(
        .MAX_DIMENSION (MAX_DIMENSION),
        .GRID_POINTS   (GRID_POINTS)
    ) u_col_grid (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (cfg_write),
        .i_adv     (pixel_take),
        .i_span    (col_span),
        .o_sampled (col_sampled),
        .o_at_end  (col_end)
    );

    ptap_grid #(
        .MAX_DIMENSION (MAX_DIMENSION),
        .GRID_POINTS   (GRID_POINTS)
    ) u_row_grid (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (cfg_write),
        .i_adv     (pixel_take && col_end),
        .i_span    (row_span),
        .o_sampled (row_sampled),
        .o_at_end  (row_end)
    );

    ptap_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_restart       (cfg_write),
        .i_move          (s1_move),
        .i_word          (r_s1_word),
        .i_ctl           (r_s1_ctl),
        .i_format        (r_format),
        .i_auto          (r_auto),
        .i_argb_ready    (i_argb_ready),
        .o_free          (out_free),
        .o_argb_valid    (o_argb_valid),
        .o_argb_word     (o_argb_word),
        .o_frame_last    (o_frame_last),
        .o_verdict_valid (o_verdict_valid),
        .o_want_xrgb     (o_want_xrgb)
    );

endmodule
